// File: rtl/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// shared types and constants for the clock divider rate calculator
// ----------------------------------------------------------------------------
package dcr_pkg;

    // command and clock kind codes
    typedef enum logic {
        CMD_FWD = 1'b0,
        CMD_REV = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_PLL  = 2'd0,
        KIND_UART = 2'd1,
        KIND_SD   = 2'd2,
        KIND_GATE = 2'd3
    } t_kind;

    // fixed rates and limits
    localparam logic [29:0] XTAL_HZ       = 30'd24000000;
    localparam logic [29:0] PLL_UNIT_HZ   = 30'd6000000;
    localparam logic [31:0] SD_MIN_HZ     = 32'd187500;
    localparam logic [31:0] SD_MAX_HZ     = 32'd200000000;
    localparam logic [8:0]  UART_MAX_CODE = 9'd312;
    localparam logic [15:0] UART_LONG_DIV = 16'd624;
    localparam int          SD_PRE_SHIFT  = 7;
    localparam logic [6:0]  PLL_MULT_RST  = 7'd100;

    // word context carried alongside the dividers
    typedef struct packed {
        t_cmd        cmd;
        t_kind       kind;
        logic [31:0] req;
        logic [29:0] pll;
        logic [8:0]  code;
    } t_side;

endpackage

// File: rtl/dcr_div_cell.sv
// ----------------------------------------------------------------------------
// dcr_div_cell
// one restoring division step with a pipeline register and handshake
// ----------------------------------------------------------------------------
module dcr_div_cell #(
    parameter int NW  = 30,
    parameter int DW  = 32,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [NW-1:0]  i_nq,
    input  logic [DW-1:0]  i_rem,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [NW-1:0]  o_nq,
    output logic [DW-1:0]  o_rem,
    output logic [DW-1:0]  o_den,
    output logic [SBW-1:0] o_sb
);

    logic           r_v;
    logic [NW-1:0]  r_nq;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [SBW-1:0] r_sb;

    logic [DW:0]    w_trial;
    logic [DW:0]    w_diff;
    logic           w_ge;
    logic [NW-1:0]  n_nq;
    logic [DW-1:0]  n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {i_rem, i_nq[NW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_nq    = {i_nq[NW-2:0], w_ge};
    end

    assign o_ready = !r_v || i_ready;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_nq  <= n_nq;
            r_rem <= n_rem;
            r_den <= i_den;
            r_sb  <= i_sb;
        end
    end

    assign o_valid = r_v;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_sb    = r_sb;

endmodule

// File: rtl/dcr_div.sv
// ----------------------------------------------------------------------------
// dcr_div
// pipelined unsigned divider, a row of one-bit division cells
// ----------------------------------------------------------------------------
module dcr_div #(
    parameter int NW  = 30,
    parameter int DW  = 32,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [NW-1:0]  o_quo,
    output logic [DW-1:0]  o_rem,
    output logic [SBW-1:0] o_sb
);

    logic           w_v   [0:NW];
    logic           w_rdy [0:NW];
    logic [NW-1:0]  w_nq  [0:NW];
    logic [DW-1:0]  w_rem [0:NW];
    logic [DW-1:0]  w_den [0:NW];
    logic [SBW-1:0] w_sb  [0:NW];

    // chain head
    assign w_v[0]   = i_valid;
    assign o_ready  = w_rdy[0];
    assign w_nq[0]  = i_num;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;
    assign w_sb[0]  = i_sb;

    // one cell per quotient bit, numerator shifts out as quotient shifts in
    for (genvar g = 0; g < NW; g++) begin : g_cell
        dcr_div_cell #(
            .NW  (NW),
            .DW  (DW),
            .SBW (SBW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_nq    (w_nq[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_sb    (w_sb[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_nq    (w_nq[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_sb    (w_sb[g+1])
        );
    end

    // chain tail
    assign w_rdy[NW] = i_ready;
    assign o_valid   = w_v[NW];
    assign o_quo     = w_nq[NW];
    assign o_rem     = w_rem[NW];
    assign o_sb      = w_sb[NW];

endmodule

// File: rtl/clock_divider_rate_calculator_top.sv
// ----------------------------------------------------------------------------
// clock_divider_rate_calculator_top
// pipeline: prep stage, 30-cell divider, code stage, 30-cell divider,
//   output register
// throughput: one word per cycle while the output is not held back; each divider cell does one quotient bit
// reset: clears all valid bits and loads the pll multiplier with 100
// ----------------------------------------------------------------------------
module clock_divider_rate_calculator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: pll multiplier
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // [31:0] requested_rate, [40:32] divider_code
    input  logic [2:0]  i_s_axis_tuser,  // [0] cmd, [2:1] clock_kind
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // [8:0] code_out, [40:9] rate_out
);

    localparam int NW  = 30;
    localparam int SBW = $bits(dcr_pkg::t_side);

    // stage ready signals, driven further down the row
    logic                 w_d1_ready;
    logic                 w_c_ready;
    logic                 w_d2_ready;
    logic                 w_o_ready;

    // configuration register
    logic [6:0] r_mult;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= dcr_pkg::PLL_MULT_RST;
        end else if (i_cfg_wen) begin
            r_mult <= i_cfg_wdata;
        end
    end

    // ---------------- prep stage ----------------
    logic                 w_a_ready;
    logic                 r_a_v;
    logic [NW-1:0]        r_a_num;
    logic [31:0]          r_a_den;
    dcr_pkg::t_side       r_a_sb;

    logic [31:0]          w_req1;
    logic [31:0]          w_sdr;
    logic [29:0]          w_p;
    logic [NW-1:0]        n_a_num;
    logic [31:0]          n_a_den;
    dcr_pkg::t_side       n_a_sb;

    // zero request, pll rate, sd clamp and first divide operands
    always_comb begin
        w_req1 = (i_s_axis_tdata[31:0] == 32'd0) ? 32'd1 : i_s_axis_tdata[31:0];
        w_p    = {23'd0, r_mult} * dcr_pkg::PLL_UNIT_HZ;
        if (w_req1 < dcr_pkg::SD_MIN_HZ) begin
            w_sdr = dcr_pkg::SD_MIN_HZ;
        end else if (w_req1 > dcr_pkg::SD_MAX_HZ) begin
            w_sdr = dcr_pkg::SD_MAX_HZ;
        end else begin
            w_sdr = w_req1;
        end
        n_a_sb.cmd  = dcr_pkg::t_cmd'(i_s_axis_tuser[0]);
        n_a_sb.kind = dcr_pkg::t_kind'(i_s_axis_tuser[2:1]);
        n_a_sb.req  = w_req1;
        n_a_sb.pll  = w_p;
        n_a_sb.code = i_s_axis_tdata[40:32];
        case (n_a_sb.kind)
            dcr_pkg::KIND_UART: begin
                n_a_num = dcr_pkg::XTAL_HZ;
                n_a_den = w_req1;
            end
            dcr_pkg::KIND_SD: begin
                n_a_num = w_p;
                n_a_den = {w_sdr[30:0], 1'b0};
            end
            default: begin
                n_a_num = w_p;
                n_a_den = 32'd1;
            end
        endcase
    end

    assign w_a_ready       = !r_a_v || w_d1_ready;
    assign o_s_axis_tready = w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_a_ready) begin
            r_a_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_s_axis_tvalid) begin
            r_a_num <= n_a_num;
            r_a_den <= n_a_den;
            r_a_sb  <= n_a_sb;
        end
    end

    // ---------------- first divider ----------------
    logic                 w_b_v;
    logic [NW-1:0]        w_b_q;
    logic [31:0]          w_b_rem;
    logic [SBW-1:0]       w_b_sbv;
    dcr_pkg::t_side       w_b_sb;

    dcr_div #(
        .NW  (NW),
        .DW  (32),
        .SBW (SBW)
    ) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (w_d1_ready),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_sb    (r_a_sb),
        .o_valid (w_b_v),
        .i_ready (w_c_ready),
        .o_quo   (w_b_q),
        .o_rem   (w_b_rem),
        .o_sb    (w_b_sbv)
    );
    assign w_b_sb = dcr_pkg::t_side'(w_b_sbv);

    // ---------------- code stage ----------------
    logic                 r_c_v;
    logic [NW-1:0]        r_c_num;
    logic [15:0]          r_c_den;
    dcr_pkg::t_side       r_c_sb;

    logic [8:0]           w_ucode;
    logic [8:0]           w_scode;
    logic [8:0]           w_pc;
    logic [7:0]           w_nc;
    logic [8:0]           w_code;
    logic [NW-1:0]        n_c_num;
    logic [15:0]          n_c_den;
    dcr_pkg::t_side       n_c_sb;

    // divider code from the first quotient, then the second divide operands
    always_comb begin
        // uart: quotient of zero gives code 0, long divides use code 312 (divisor 624)
        if (w_b_q == '0) begin
            w_ucode = 9'd0;
        end else if (w_b_q > NW'(dcr_pkg::UART_MAX_CODE)) begin
            w_ucode = dcr_pkg::UART_MAX_CODE;
        end else begin
            w_ucode = w_b_q[8:0] - 9'd1;
        end
        // sd: ceiling divide, prescaled when the quotient reaches 128
        w_pc = w_b_q[15:7] + {8'd0, (w_b_q[6:0] != 7'd0)};
        w_nc = {1'b0, w_b_q[6:0]} + {7'd0, (w_b_rem != 32'd0)};
        if (w_b_q[NW-1:7] != '0) begin
            w_scode = {1'b1, w_pc[7:0] - 8'd1};
        end else if (w_nc == 8'd0) begin
            w_scode = 9'd0;
        end else begin
            w_scode = {1'b0, w_nc - 8'd1};
        end
        // pick the code
        if (w_b_sb.cmd == dcr_pkg::CMD_REV) begin
            w_code = w_b_sb.code;
        end else if (w_b_sb.kind == dcr_pkg::KIND_UART) begin
            w_code = w_ucode;
        end else if (w_b_sb.kind == dcr_pkg::KIND_SD) begin
            w_code = w_scode;
        end else begin
            w_code = 9'd0;
        end
        // side data carries the chosen code on
        n_c_sb      = w_b_sb;
        n_c_sb.code = w_code;
        // divide for the code
        case (w_b_sb.kind)
            dcr_pkg::KIND_UART: begin
                n_c_num = dcr_pkg::XTAL_HZ;
                n_c_den = (w_code == dcr_pkg::UART_MAX_CODE) ? dcr_pkg::UART_LONG_DIV
                                                             : {7'd0, w_code} + 16'd1;
            end
            dcr_pkg::KIND_SD: begin
                n_c_num = w_b_sb.pll;
                n_c_den = w_code[8] ? (({8'd0, w_code[7:0]} + 16'd1) << dcr_pkg::SD_PRE_SHIFT)
                                    : {7'd0, w_code} + 16'd1;
            end
            default: begin
                n_c_num = w_b_sb.pll;
                n_c_den = 16'd1;
            end
        endcase
    end

    assign w_c_ready = !r_c_v || w_d2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_c_ready) begin
            r_c_v <= w_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && w_b_v) begin
            r_c_num <= n_c_num;
            r_c_den <= n_c_den;
            r_c_sb  <= n_c_sb;
        end
    end

    // ---------------- second divider ----------------
    logic                 w_e_v;
    logic [NW-1:0]        w_e_q;
    logic [15:0]          w_e_rem;
    logic [SBW-1:0]       w_e_sbv;
    dcr_pkg::t_side       w_e_sb;

    dcr_div #(
        .NW  (NW),
        .DW  (16),
        .SBW (SBW)
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .o_ready (w_d2_ready),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_sb    (r_c_sb),
        .o_valid (w_e_v),
        .i_ready (w_o_ready),
        .o_quo   (w_e_q),
        .o_rem   (w_e_rem),
        .o_sb    (w_e_sbv)
    );
    assign w_e_sb = dcr_pkg::t_side'(w_e_sbv);

    // ---------------- output register ----------------
    logic                 r_o_v;
    logic [8:0]           r_o_code;
    logic [31:0]          r_o_rate;
    dcr_pkg::t_cmd        r_o_cmd;
    dcr_pkg::t_kind       r_o_kind;
    logic [31:0]          n_o_rate;
    logic                 w_rem_unused;

    // achieved rate per kind
    always_comb begin
        w_rem_unused = |w_e_rem;
        case (w_e_sb.kind)
            dcr_pkg::KIND_UART: n_o_rate = {2'd0, w_e_q};
            dcr_pkg::KIND_SD:   n_o_rate = {3'd0, w_e_q[NW-1:1]};
            dcr_pkg::KIND_PLL:  n_o_rate = {2'd0, w_e_sb.pll};
            default: begin
                n_o_rate = (w_e_sb.cmd == dcr_pkg::CMD_FWD) ? w_e_sb.req : 32'd0;
            end
        endcase
    end

    assign w_o_ready = !r_o_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_o_ready) begin
            r_o_v <= w_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_ready && w_e_v) begin
            r_o_code <= w_e_sb.code;
            r_o_rate <= n_o_rate | {31'd0, w_rem_unused & 1'b0};
            r_o_cmd  <= w_e_sb.cmd;
            r_o_kind <= w_e_sb.kind;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {7'd0, r_o_rate, r_o_code};

    // ---------------- assertions ----------------
    // input side only stalls when the whole row is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while pipeline has room");

    // forward uart codes never exceed the long-divide code
    a_uart_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_cmd == dcr_pkg::CMD_FWD && r_o_kind == dcr_pkg::KIND_UART)
            |-> (r_o_code <= dcr_pkg::UART_MAX_CODE))
        else $error("uart forward code out of range");

    // forward sd rate never exceeds the sd ceiling
    a_sd_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_cmd == dcr_pkg::CMD_FWD && r_o_kind == dcr_pkg::KIND_SD)
            |-> (r_o_rate <= dcr_pkg::SD_MAX_HZ))
        else $error("sd forward rate above limit");

    // forward pll and gate words carry a zero code
    a_fwd_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_cmd == dcr_pkg::CMD_FWD
            && (r_o_kind == dcr_pkg::KIND_PLL || r_o_kind == dcr_pkg::KIND_GATE))
            |-> (r_o_code == 9'd0))
        else $error("nonzero code on pll or gate forward word");

endmodule
